/* rtl/scsp_pkg.sv */
`timescale 1ns / 1ps
// package: phase and event codes, opcodes and the result record of the slice command parser
package scsp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned WordW  = 16;
  localparam int unsigned CountW = 4;
  localparam int unsigned WordsW = 18;

  localparam logic [ByteW-1:0] OpHeader   = 8'd1;
  localparam logic [ByteW-1:0] OpLayerEnd = 8'd2;
  localparam logic [ByteW-1:0] OpPolyline = 8'd3;
  localparam logic [ByteW-1:0] OpHatch    = 8'd4;

  localparam logic [CountW-1:0] HdrSkipBytes = 4'd8;
  localparam logic [CountW-1:0] WordBytes    = 4'd2;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_OPCODE,
    PH_HDR_POS,
    PH_HDR_SKIP,
    PH_HDR_PAD,
    PH_SHAPE_PAD,
    PH_SHAPE_COUNT,
    PH_COORD
  } phase_e;

  typedef enum logic [2:0] {
    EV_HEADER   = 3'd0,
    EV_POLY     = 3'd1,
    EV_HATCH    = 3'd2,
    EV_COORD    = 3'd3,
    EV_END      = 3'd4,
    EV_BAD_OP   = 3'd5,
    EV_BAD_PAD  = 3'd6
  } event_e;

  typedef struct packed {
    logic             valid;
    event_e           ev;
    logic [WordW-1:0] value;
    logic             last;
    logic             warn;
  } scsp_res_t;

endpackage

/* rtl/scsp_core.sv */
`timescale 1ns / 1ps
// parser state registers and the per-byte next-state and result logic
module scsp_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [scsp_pkg::ByteW-1:0] byte_i,
  input  logic                      start_i,
  output scsp_pkg::scsp_res_t       res_o
);
  import scsp_pkg::*;

  phase_e            phase_q, phase_d;
  logic [CountW-1:0] bytes_left_q, bytes_left_d;
  logic [WordsW-1:0] words_left_q, words_left_d;
  logic [ByteW-1:0]  hold_q, hold_d;
  logic [WordW-1:0]  position_q, position_d;
  logic              hatch_q, hatch_d;
  logic [WordW-1:0]  word;
  logic [WordsW-1:0] words_dec;
  logic [WordsW-1:0] words_new;

  assign word      = {hold_q, byte_i};
  assign words_dec = words_left_q - WordsW'(1);
  assign words_new = hatch_q ? {word, 2'b00} : {1'b0, word, 1'b0};

  always_comb begin
    phase_d      = phase_q;
    bytes_left_d = bytes_left_q;
    words_left_d = words_left_q;
    hold_d       = hold_q;
    position_d   = position_q;
    hatch_d      = hatch_q;
    res_o        = '0;
    if (start_i || phase_q == PH_OPCODE) begin
      bytes_left_d = '0;
      words_left_d = '0;
      case (byte_i)
        OpHeader: begin
          phase_d      = PH_HDR_POS;
          bytes_left_d = WordBytes;
        end
        OpLayerEnd: begin
          phase_d     = PH_IDLE;
          res_o.valid = 1'b1;
          res_o.ev    = EV_END;
        end
        OpPolyline, OpHatch: begin
          hatch_d = (byte_i == OpHatch);
          phase_d = PH_SHAPE_PAD;
        end
        default: begin
          phase_d     = PH_IDLE;
          res_o.valid = 1'b1;
          res_o.ev    = EV_BAD_OP;
          res_o.value = {{(WordW-ByteW){1'b0}}, byte_i};
        end
      endcase
    end else begin
      case (phase_q)
        PH_HDR_POS: begin
          if (bytes_left_q == WordBytes) begin
            hold_d       = byte_i;
            bytes_left_d = CountW'(1);
          end else begin
            position_d   = word;
            phase_d      = PH_HDR_SKIP;
            bytes_left_d = HdrSkipBytes;
          end
        end
        PH_HDR_SKIP: begin
          if (bytes_left_q > CountW'(1)) begin
            bytes_left_d = bytes_left_q - CountW'(1);
          end else begin
            bytes_left_d = '0;
            phase_d      = PH_HDR_PAD;
          end
        end
        PH_HDR_PAD: begin
          phase_d     = PH_OPCODE;
          res_o.valid = 1'b1;
          res_o.ev    = EV_HEADER;
          res_o.value = position_q;
          res_o.warn  = (byte_i != '0);
        end
        PH_SHAPE_PAD: begin
          if (byte_i != '0) begin
            phase_d     = PH_IDLE;
            res_o.valid = 1'b1;
            res_o.ev    = EV_BAD_PAD;
            res_o.value = {{(WordW-ByteW){1'b0}}, byte_i};
          end else begin
            phase_d      = PH_SHAPE_COUNT;
            bytes_left_d = WordBytes;
          end
        end
        PH_SHAPE_COUNT: begin
          if (bytes_left_q == WordBytes) begin
            hold_d       = byte_i;
            bytes_left_d = CountW'(1);
          end else begin
            words_left_d = words_new;
            bytes_left_d = WordBytes;
            phase_d      = (words_new != '0) ? PH_COORD : PH_OPCODE;
            res_o.valid  = 1'b1;
            res_o.ev     = hatch_q ? EV_HATCH : EV_POLY;
            res_o.value  = word;
          end
        end
        PH_COORD: begin
          if (bytes_left_q == WordBytes) begin
            hold_d       = byte_i;
            bytes_left_d = CountW'(1);
          end else begin
            bytes_left_d = WordBytes;
            words_left_d = words_dec;
            res_o.valid  = 1'b1;
            res_o.ev     = EV_COORD;
            res_o.value  = word;
            if (words_dec == '0) begin
              phase_d      = PH_OPCODE;
              bytes_left_d = '0;
              res_o.last   = 1'b1;
            end
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      bytes_left_q <= '0;
      words_left_q <= '0;
      hold_q       <= '0;
      position_q   <= '0;
      hatch_q      <= 1'b0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      bytes_left_q <= bytes_left_d;
      words_left_q <= words_left_d;
      hold_q       <= hold_d;
      position_q   <= position_d;
      hatch_q      <= hatch_d;
    end
  end

endmodule

/* rtl/scsp_out_reg.sv */
`timescale 1ns / 1ps
// result register with valid/ready hand-off to the receiver
module scsp_out_reg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  scsp_pkg::scsp_res_t          res_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [2:0]                   event_res_o,
  output logic [scsp_pkg::WordW-1:0]   value_o,
  output logic                         last_in_shape_o,
  output logic                         pad_warning_o
);
  import scsp_pkg::*;

  logic      valid_q, valid_d;
  scsp_res_t res_q;

  assign valid_d = load_i ? 1'b1 : (out_ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o     = valid_q;
  assign event_res_o     = res_q.ev;
  assign value_o         = res_q.value;
  assign last_in_shape_o = res_q.last;
  assign pad_warning_o   = res_q.warn;

endmodule

/* rtl/slice_command_stream_parser.sv */
`timescale 1ns / 1ps
// top level of the slice command stream parser: input register, parser core, result register
//
// usage
//   in channel: one byte of a layer command stream per request, with layer_start_i
//   high on the first byte of a layer (that byte is parsed as an opcode)
//   out channel: zero or one event per byte - header, polyline or hatch start,
//   coordinate word, layer end, bad opcode or bad padding
//   a request accepted at one edge is parsed at the next edge that has room in the
//   result register; its event is on the outputs from that edge on
//   throughput is one byte per cycle while the receiver does not stall
//   bytes that give no event still pass through the input register
//   when the receiver stalls, the held event keeps the parser from stepping, the
//   input register fills and in_ready_o falls; nothing is lost or repeated
//   reset clears the input and result valid flags and puts the parser in idle,
//   where it ignores bytes until the next layer start
//   no parameters, no configuration port
module slice_command_stream_parser (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [scsp_pkg::ByteW-1:0] data_byte_i,
  input  logic                       layer_start_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [2:0]                 event_res_o,
  output logic [scsp_pkg::WordW-1:0] value_o,
  output logic                       last_in_shape_o,
  output logic                       pad_warning_o
);
  import scsp_pkg::*;

  logic             in_valid_q, in_valid_d;
  logic [ByteW-1:0] in_byte_q;
  logic             in_start_q;
  logic             advance;
  logic             step;
  logic             take;
  scsp_res_t        res;

  assign advance    = !out_valid_o || out_ready_i;
  assign step       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;
  assign take       = in_valid_i && in_ready_o;
  assign in_valid_d = take ? 1'b1 : (step ? 1'b0 : in_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_byte_q  <= data_byte_i;
      in_start_q <= layer_start_i;
    end
  end

  scsp_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .byte_i  (in_byte_q),
    .start_i (in_start_q),
    .res_o   (res)
  );

  scsp_out_reg u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (step && res.valid),
    .res_i           (res),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .event_res_o     (event_res_o),
    .value_o         (value_o),
    .last_in_shape_o (last_in_shape_o),
    .pad_warning_o   (pad_warning_o)
  );

endmodule

/* rtl/scsp_checker.sv */
`timescale 1ns / 1ps
// port-level checker for the slice command stream parser and its bind
module scsp_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic [scsp_pkg::ByteW-1:0] data_byte_i,
  input logic                       layer_start_i,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [2:0]                 event_res_o,
  input logic [scsp_pkg::WordW-1:0] value_o,
  input logic                       last_in_shape_o,
  input logic                       pad_warning_o
);
  import scsp_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pad_warning_o |-> event_res_o == EV_HEADER)
    else $error("pad warning on a non-header event");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_in_shape_o |-> event_res_o == EV_COORD)
    else $error("last-in-shape on a non-coordinate event");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_res_o == EV_BAD_OP || event_res_o == EV_BAD_PAD || event_res_o == EV_END)
      |-> value_o[WordW-1:ByteW] == '0)
    else $error("byte-sized event value has upper bits set");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(value_o) && $stable(event_res_o))
    else $error("stalled result changed");

  // a waiting request keeps its byte and layer start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o
      |=> in_valid_i && $stable(data_byte_i) && $stable(layer_start_i))
    else $error("waiting request changed");

endmodule

bind slice_command_stream_parser scsp_checker u_scsp_checker (.*);
